// ===== rtl/arp_pkg.sv =====
`default_nettype none

package arp_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 24;
  localparam int CORDIC_ITERS    = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int NUM_REGS        = 7;

  localparam logic [63:0] DEGEN_LIM =
    ((64'd1 << (2 * COORD_FRAC_BITS)) - 64'd1) / 64'd1000000000;

  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] HALF_Q30    = 34'sd536870912;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_PX    = 3'd0,
    REG_PY    = 3'd1,
    REG_PZ    = 3'd2,
    REG_DX    = 3'd3,
    REG_DY    = 3'd4,
    REG_DZ    = 3'd5,
    REG_ANGLE = 3'd6
  } arp_reg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } arp_point_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [18:0] angle;
  } arp_cfg_t;

  typedef struct packed {
    logic [8:0][31:0] r;
    logic [2:0][34:0] t;
  } arp_coef_t;

  typedef struct packed {
    logic done;
    logic degen;
  } arp_sts_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // round half up of a q30 product
  function automatic logic signed [33:0] mq_round(input logic signed [67:0] p);
    logic signed [67:0] s;
    s = p + 68'(HALF_Q30);
    return s[63:30];
  endfunction

  function automatic logic signed [33:0] clamp_one(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > ONE_Q30) begin
      r = ONE_Q30;
    end else if (v < -ONE_Q30) begin
      r = -ONE_Q30;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/axis_angle_point_rotator.sv =====
// the row sequencer takes one item at a time, and only when the matrix is current; per row a
// multiply then a sum, then the output register and the return to idle, before the next item
// after a register write the next item first waits for the matrix rebuild (square root,
// three divides, cordic, coefficient sequencer)
// reset: synchronous active low, registers to defaults, matrix marked for rebuild
`default_nettype none

module axis_angle_point_rotator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_axis_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import arp_pkg::*;

  arp_cfg_t   cfg_r;
  logic       stale_r;
  arp_point_t in_pt;
  logic       q_valid;
  arp_point_t q_data;
  logic       q_pop;
  logic       build_start;
  arp_sts_t   build_sts;
  arp_coef_t  coef;
  logic       cfg_hit;

  assign in_pt.x = in_x;
  assign in_pt.y = in_y;
  assign in_pt.z = in_z;
  assign cfg_hit = cfg_we && (cfg_index < 3'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.px    <= '0;
      cfg_r.py    <= '0;
      cfg_r.pz    <= '0;
      cfg_r.dx    <= '0;
      cfg_r.dy    <= '0;
      cfg_r.dz    <= 32'sd65536;
      cfg_r.angle <= '0;
      stale_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (arp_reg_t'(cfg_index))
          REG_PX:    cfg_r.px    <= cfg_data;
          REG_PY:    cfg_r.py    <= cfg_data;
          REG_PZ:    cfg_r.pz    <= cfg_data;
          REG_DX:    cfg_r.dx    <= cfg_data;
          REG_DY:    cfg_r.dy    <= cfg_data;
          REG_DZ:    cfg_r.dz    <= cfg_data;
          REG_ANGLE: cfg_r.angle <= cfg_data[18:0];
          default:   ;
        endcase
      end
      if (cfg_hit) begin
        stale_r <= 1'b1;
      end else if (build_start) begin
        stale_r <= 1'b0;
      end
    end
  end

  arp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_pt),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  arp_matrix u_matrix (
    .clk         (clk),
    .rst_n       (rst_n),
    .build_start (build_start),
    .cfg         (cfg_r),
    .sts         (build_sts),
    .coef        (coef)
  );

  arp_xform u_xform (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .stale          (stale_r),
    .build_start    (build_start),
    .sts            (build_sts),
    .coef           (coef),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_axis_error (out_axis_error)
  );

`ifndef SYNTH
  a_start_clears_stale: assert property (@(posedge clk) disable iff (!rst_n)
    build_start && !cfg_hit |=> !stale_r)
    else $error("rebuild started but matrix still marked stale");

  a_done_not_with_start: assert property (@(posedge clk) disable iff (!rst_n)
    build_sts.done |-> !build_start)
    else $error("rebuild start while previous rebuild finishing");

  a_write_marks_stale: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> stale_r)
    else $error("register write did not schedule rebuild");

  a_no_pop_when_stale: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !stale_r && q_valid)
    else $error("item taken with stale matrix");
`endif

endmodule

`default_nettype wire

// ===== rtl/arp_queue.sv =====
`default_nettype none

module arp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  arp_pkg::arp_point_t in_data,
  output logic                q_valid,
  output arp_pkg::arp_point_t q_data,
  input  logic                q_pop
);
  import arp_pkg::*;

  arp_point_t mem_r [0:1];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (q_pop) begin
        rp_r <= !rp_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arp_matrix.sv =====
`default_nettype none

module arp_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               build_start,
  input  arp_pkg::arp_cfg_t  cfg,
  output arp_pkg::arp_sts_t  sts,
  output arp_pkg::arp_coef_t coef
);
  import arp_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_SQ, M_CHK, M_NORM, M_LEN, M_SQRT, M_DIVI, M_DIV,
    M_CORDI, M_CORD, M_CSC, M_MQ, M_MAT, M_TR, M_DONE
  } state_t;

  typedef enum logic [3:0] {
    MQ_XX, MQ_YY, MQ_ZZ, MQ_Q01, MQ_Q02, MQ_Q12, MQ_XY, MQ_XZ, MQ_YZ,
    MQ_SX, MQ_SY, MQ_SZ, MQ_CA, MQ_CB, MQ_CC
  } mq_step_t;

  state_t             state_r;
  mq_step_t           step_r;
  logic               done_r;
  logic               degen_r;
  logic               ph_r;
  logic [1:0]         k_r;
  logic [4:0]         it_r;
  logic signed [32:0] d_r [0:2];
  logic [31:0]        mx_r;
  logic [63:0]        sum_r;
  logic [63:0]        n_r;
  logic [63:0]        rt_r;
  logic [63:0]        bit_r;
  logic [32:0]        len_r;
  logic [62:0]        rem_r;
  logic [62:0]        dv_r;
  logic [30:0]        q_r;
  logic signed [33:0] u_r [0:2];
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic signed [33:0] cs_r, sn_r, omc_r;
  logic signed [33:0] xx_r, yy_r, zz_r, q01_r, q02_r, q12_r;
  logic signed [33:0] xy_r, xz_r, yz_r, sx_r, sy_r, sz_r, ca_r, cb_r, cc_r;
  logic signed [67:0] prod_r;
  logic signed [63:0] acc_r;
  logic [1:0]         trow_r;
  logic [1:0]         tcol_r;
  arp_coef_t          coef_r;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] n;
    n = -v;
    return v[31] ? n : v;
  endfunction

  logic [31:0]        ax, ay, az, mx0;
  logic signed [32:0] dsel, dneg;
  logic [31:0]        mag;
  logic [63:0]        sq, sum_nxt;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [63:0]        n_nxt, rt_nxt;
  logic               dv_ge;
  logic [30:0]        q_nxt;
  logic signed [33:0] qs, u_nxt;
  logic signed [33:0] za, zf;
  logic               ff;
  logic signed [33:0] xs, ys, at, x_nxt, y_nxt, z_nxt;
  logic signed [33:0] cf, sf, cc_cl;
  logic signed [33:0] opa, opb, mul_a, mul_b, mqv;
  logic signed [67:0] prod;
  logic [3:0]         ridx;
  logic signed [31:0] pcol, prow;
  logic signed [63:0] acc_nxt, tr;
  logic signed [33:0] m [0:8];

  always_comb begin
    ax  = abs32(cfg.dx);
    ay  = abs32(cfg.dy);
    az  = abs32(cfg.dz);
    mx0 = ax;
    if (ay > mx0) begin
      mx0 = ay;
    end
    if (az > mx0) begin
      mx0 = az;
    end
  end

  assign dsel    = d_r[k_r];
  assign dneg    = -dsel;
  assign mag     = dsel[32] ? dneg[31:0] : dsel[31:0];
  assign sq      = mag * mag;
  assign sum_nxt = sum_r + sq;

  always_comb begin
    trial = rt_r + bit_r;
    sq_ge = (n_r >= trial);
    n_nxt  = sq_ge ? (n_r - trial) : n_r;
    rt_nxt = sq_ge ? ((rt_r >> 1) + bit_r) : (rt_r >> 1);
  end

  always_comb begin
    dv_ge = (rem_r >= dv_r);
    q_nxt = {q_r[29:0], dv_ge};
    qs    = {3'b000, q_nxt};
    u_nxt = dsel[32] ? -qs : qs;
  end

  always_comb begin
    za = {cfg.angle[18], cfg.angle, 14'b0};
    zf = za;
    ff = 1'b0;
    if (za > HALF_PI_Q30) begin
      zf = za - PI_Q30;
      ff = 1'b1;
    end else if (za < -HALF_PI_Q30) begin
      zf = za + PI_Q30;
      ff = 1'b1;
    end
  end

  always_comb begin
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    at = atan_q30(it_r);
    if (!z_r[33]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
  end

  assign cf    = flip_r ? -x_r : x_r;
  assign sf    = flip_r ? -y_r : y_r;
  assign cc_cl = clamp_one(cf);

  always_comb begin
    case (step_r)
      MQ_XX:   begin opa = u_r[0];      opb = u_r[0]; end
      MQ_YY:   begin opa = u_r[1];      opb = u_r[1]; end
      MQ_ZZ:   begin opa = u_r[2];      opb = u_r[2]; end
      MQ_Q01:  begin opa = u_r[0];      opb = u_r[1]; end
      MQ_Q02:  begin opa = u_r[0];      opb = u_r[2]; end
      MQ_Q12:  begin opa = u_r[1];      opb = u_r[2]; end
      MQ_XY:   begin opa = q01_r;       opb = omc_r;  end
      MQ_XZ:   begin opa = q02_r;       opb = omc_r;  end
      MQ_YZ:   begin opa = q12_r;       opb = omc_r;  end
      MQ_SX:   begin opa = u_r[0];      opb = sn_r;   end
      MQ_SY:   begin opa = u_r[1];      opb = sn_r;   end
      MQ_SZ:   begin opa = u_r[2];      opb = sn_r;   end
      MQ_CA:   begin opa = yy_r + zz_r; opb = cs_r;   end
      MQ_CB:   begin opa = xx_r + zz_r; opb = cs_r;   end
      MQ_CC:   begin opa = xx_r + yy_r; opb = cs_r;   end
      default: begin opa = '0;          opb = '0;     end
    endcase
  end

  always_comb begin
    case (tcol_r)
      2'd0:    pcol = cfg.px;
      2'd1:    pcol = cfg.py;
      default: pcol = cfg.pz;
    endcase
    case (trow_r)
      2'd0:    prow = cfg.px;
      2'd1:    prow = cfg.py;
      default: prow = cfg.pz;
    endcase
  end

  assign ridx  = 4'(trow_r) * 4'd3 + 4'(tcol_r);
  assign mul_a = (state_r == M_TR) ? 34'(signed'(coef_r.r[ridx])) : opa;
  assign mul_b = (state_r == M_TR) ? 34'(pcol) : opb;
  assign prod  = mul_a * mul_b;
  assign mqv   = mq_round(prod_r);

  assign acc_nxt = acc_r + prod_r[63:0];
  assign tr      = acc_nxt + 64'(HALF_Q30);

  always_comb begin
    m[0] = xx_r + ca_r;
    m[1] = xy_r - sz_r;
    m[2] = xz_r + sy_r;
    m[3] = xy_r + sz_r;
    m[4] = yy_r + cb_r;
    m[5] = yz_r - sx_r;
    m[6] = xz_r - sy_r;
    m[7] = yz_r + sx_r;
    m[8] = zz_r + cc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      degen_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (build_start) begin
            d_r[0]  <= 33'(cfg.dx);
            d_r[1]  <= 33'(cfg.dy);
            d_r[2]  <= 33'(cfg.dz);
            mx_r    <= mx0;
            sum_r   <= '0;
            k_r     <= 2'd0;
            state_r <= M_SQ;
          end
        end
        M_SQ: begin
          sum_r <= sum_nxt;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd2) begin
            state_r <= M_CHK;
          end
        end
        M_CHK: begin
          k_r   <= 2'd0;
          sum_r <= '0;
          if (sum_r <= DEGEN_LIM || mx_r == 32'd0) begin
            degen_r <= 1'b1;
            state_r <= M_DONE;
          end else begin
            degen_r <= 1'b0;
            state_r <= M_NORM;
          end
        end
        M_NORM: begin
          if (mx_r < 32'd1073741824) begin
            mx_r   <= mx_r << 1;
            d_r[0] <= d_r[0] <<< 1;
            d_r[1] <= d_r[1] <<< 1;
            d_r[2] <= d_r[2] <<< 1;
          end else begin
            state_r <= M_LEN;
          end
        end
        M_LEN: begin
          sum_r <= sum_nxt;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd2) begin
            n_r     <= sum_nxt;
            rt_r    <= '0;
            bit_r   <= 64'd1 << 62;
            it_r    <= 5'd0;
            state_r <= M_SQRT;
          end
        end
        M_SQRT: begin
          n_r   <= n_nxt;
          rt_r  <= rt_nxt;
          bit_r <= bit_r >> 2;
          it_r  <= it_r + 5'd1;
          if (it_r == 5'd31) begin
            len_r   <= rt_nxt[32:0];
            k_r     <= 2'd0;
            state_r <= M_DIVI;
          end
        end
        M_DIVI: begin
          rem_r   <= {1'b0, mag, 30'b0};
          dv_r    <= {len_r, 30'b0};
          q_r     <= '0;
          it_r    <= 5'd0;
          state_r <= M_DIV;
        end
        M_DIV: begin
          if (dv_ge) begin
            rem_r <= rem_r - dv_r;
          end
          dv_r <= dv_r >> 1;
          q_r  <= q_nxt;
          it_r <= it_r + 5'd1;
          if (it_r == 5'd30) begin
            u_r[k_r] <= u_nxt;
            k_r      <= k_r + 2'd1;
            state_r  <= (k_r == 2'd2) ? M_CORDI : M_DIVI;
          end
        end
        M_CORDI: begin
          z_r     <= zf;
          flip_r  <= ff;
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          it_r    <= 5'd0;
          state_r <= M_CORD;
        end
        M_CORD: begin
          x_r  <= x_nxt;
          y_r  <= y_nxt;
          z_r  <= z_nxt;
          it_r <= it_r + 5'd1;
          if (it_r == 5'(CORDIC_ITERS - 1)) begin
            state_r <= M_CSC;
          end
        end
        M_CSC: begin
          cs_r    <= cc_cl;
          sn_r    <= clamp_one(sf);
          omc_r   <= ONE_Q30 - cc_cl;
          step_r  <= MQ_XX;
          ph_r    <= 1'b0;
          state_r <= M_MQ;
        end
        M_MQ: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= prod;
          end else begin
            case (step_r)
              MQ_XX:   xx_r  <= mqv;
              MQ_YY:   yy_r  <= mqv;
              MQ_ZZ:   zz_r  <= mqv;
              MQ_Q01:  q01_r <= mqv;
              MQ_Q02:  q02_r <= mqv;
              MQ_Q12:  q12_r <= mqv;
              MQ_XY:   xy_r  <= mqv;
              MQ_XZ:   xz_r  <= mqv;
              MQ_YZ:   yz_r  <= mqv;
              MQ_SX:   sx_r  <= mqv;
              MQ_SY:   sy_r  <= mqv;
              MQ_SZ:   sz_r  <= mqv;
              MQ_CA:   ca_r  <= mqv;
              MQ_CB:   cb_r  <= mqv;
              MQ_CC:   cc_r  <= mqv;
              default: ;
            endcase
            if (step_r == MQ_CC) begin
              state_r <= M_MAT;
            end else begin
              step_r <= mq_step_t'(step_r + 4'd1);
            end
          end
        end
        M_MAT: begin
          for (int i = 0; i < 9; i++) begin
            coef_r.r[i] <= 32'(clamp_one(m[i]));
          end
          acc_r   <= '0;
          trow_r  <= 2'd0;
          tcol_r  <= 2'd0;
          ph_r    <= 1'b0;
          state_r <= M_TR;
        end
        M_TR: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= prod;
          end else if (tcol_r == 2'd2) begin
            coef_r.t[trow_r] <= 35'(prow) - 35'(signed'(tr[63:30]));
            acc_r  <= '0;
            tcol_r <= 2'd0;
            trow_r <= trow_r + 2'd1;
            if (trow_r == 2'd2) begin
              state_r <= M_DONE;
            end
          end else begin
            acc_r  <= acc_nxt;
            tcol_r <= tcol_r + 2'd1;
          end
        end
        M_DONE: begin
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign sts.done  = done_r;
  assign sts.degen = degen_r;
  assign coef      = coef_r;

endmodule

`default_nettype wire

// ===== rtl/arp_xform.sv =====
`default_nettype none

module arp_xform (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  arp_pkg::arp_point_t q_data,
  output logic                q_pop,
  input  logic                stale,
  output logic                build_start,
  input  arp_pkg::arp_sts_t   sts,
  input  arp_pkg::arp_coef_t  coef,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic                out_axis_error
);
  import arp_pkg::*;

  typedef enum logic [2:0] {X_IDLE, X_BUILD, X_MUL, X_ACC, X_OUT} state_t;

  state_t             state_r;
  logic               build_start_r;
  logic [1:0]         row_r;
  arp_point_t         v_r;
  logic signed [63:0] p_r [0:2];
  logic signed [31:0] res_r [0:2];
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_err_r;

  logic [3:0]         base;
  logic signed [31:0] c0, c1, c2;
  logic signed [34:0] tk;
  logic signed [63:0] s, sr;
  logic signed [35:0] tot;
  logic signed [31:0] sat;
  logic               out_free;

  assign q_pop    = (state_r == X_IDLE) && q_valid && !stale;
  assign out_free = !out_valid_r || !out_stall;

  assign base = 4'(row_r) * 4'd3;
  assign c0   = coef.r[base];
  assign c1   = coef.r[base + 4'd1];
  assign c2   = coef.r[base + 4'd2];
  assign tk   = coef.t[row_r];

  always_comb begin
    s   = p_r[0] + p_r[1] + p_r[2];
    sr  = s + 64'(HALF_Q30);
    tot = 36'(signed'(sr[63:30])) + 36'(tk);
    if (tot > 36'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (tot < -36'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = tot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= X_IDLE;
      build_start_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      build_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        X_IDLE: begin
          if (q_valid) begin
            if (stale) begin
              build_start_r <= 1'b1;
              state_r       <= X_BUILD;
            end else begin
              v_r     <= q_data;
              row_r   <= 2'd0;
              state_r <= X_MUL;
            end
          end
        end
        X_BUILD: begin
          if (sts.done) begin
            state_r <= X_IDLE;
          end
        end
        X_MUL: begin
          p_r[0]  <= c0 * v_r.x;
          p_r[1]  <= c1 * v_r.y;
          p_r[2]  <= c2 * v_r.z;
          state_r <= X_ACC;
        end
        X_ACC: begin
          res_r[row_r] <= sat;
          row_r        <= row_r + 2'd1;
          state_r      <= (row_r == 2'd2) ? X_OUT : X_MUL;
        end
        X_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_err_r   <= sts.degen;
            out_x_r     <= sts.degen ? 32'sd0 : res_r[0];
            out_y_r     <= sts.degen ? 32'sd0 : res_r[1];
            out_z_r     <= sts.degen ? 32'sd0 : res_r[2];
            state_r     <= X_IDLE;
          end
        end
        default: state_r <= X_IDLE;
      endcase
    end
  end

  assign build_start    = build_start_r;
  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_z          = out_z_r;
  assign out_axis_error = out_err_r;

endmodule

`default_nettype wire

// ===== bench/axis_angle_point_rotator_chk.sv =====
module axis_angle_point_rotator_chk
  import arp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               out_axis_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               err;
  } rot_point_t;

  localparam longint ONE = 64'sd1073741824;
  localparam longint HALF = 64'sd536870912;

  rot_point_t rotated_q[$];
  longint regs_q[NUM_REGS];
  longint coef[12];
  bit     stale;
  bit     degen;

  function automatic longint sx(longint v, int w);
    longint m;
    m = (64'sd1 << w) - 1;
    v = v & m;
    if (v[w-1]) v = v - (64'sd1 << w);
    return v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mul30(longint a, longint b);
    return (a * b + HALF) >>> 30;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic rebuild_matrix();
    longint d[3], p[3], u[3], m[9];
    longint c, s, omc, len, z, x, y, nx, acc, v;
    longint xx, yy, zz, xy, xz, yz, ssx, ssy, ssz;
    longint unsigned sum, mx, len2, a;
    int sh;
    bit flip;
    sum = 0; mx = 0; len2 = 0; sh = 0; flip = 0;
    for (int k = 0; k < 3; k++) begin
      p[k] = sx(regs_q[k], 32);
      d[k] = sx(regs_q[3+k], 32);
      a = longint'(d[k] < 0 ? -d[k] : d[k]);
      sum += a * a;
      if (a > mx) mx = a;
    end
    degen = (sum <= DEGEN_LIM) || mx == 0;
    stale = 0;
    if (degen) return;
    while ((mx << sh) < ONE) sh++;
    for (int k = 0; k < 3; k++) begin
      d[k] = d[k] * (64'sd1 << sh);
      len2 += longint'(d[k] * d[k]);
    end
    len = root64(len2);
    for (int k = 0; k < 3; k++) u[k] = (d[k] * ONE) / len;
    z = sx(regs_q[REG_ANGLE], 19) * 16384;
    x = CORDIC_GAIN;
    y = 0;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30; flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30; flip = 1;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_q30(5'(i));
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_q30(5'(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, -ONE, ONE);
    s = clip(y, -ONE, ONE);
    omc = ONE - c;
    xx = mul30(u[0], u[0]); yy = mul30(u[1], u[1]); zz = mul30(u[2], u[2]);
    xy = mul30(mul30(u[0], u[1]), omc);
    xz = mul30(mul30(u[0], u[2]), omc);
    yz = mul30(mul30(u[1], u[2]), omc);
    ssx = mul30(u[0], s); ssy = mul30(u[1], s); ssz = mul30(u[2], s);
    m[0] = xx + mul30(yy + zz, c); m[1] = xy - ssz; m[2] = xz + ssy;
    m[3] = xy + ssz; m[4] = yy + mul30(xx + zz, c); m[5] = yz - ssx;
    m[6] = xz - ssy; m[7] = yz + ssx; m[8] = zz + mul30(xx + yy, c);
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        v = clip(m[3*k+j], -ONE, ONE);
        coef[4*k+j] = v;
        acc += v * p[j];
      end
      coef[4*k+3] = p[k] - ((acc + HALF) >>> 30);
    end
  endtask

  function automatic rot_point_t rotate_point(longint vx, longint vy, longint vz);
    rot_point_t o;
    longint v[3], r[3], acc;
    v[0] = vx; v[1] = vy; v[2] = vz;
    for (int k = 0; k < 3; k++) begin
      r[k] = 0;
      if (!degen) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += coef[4*k+j] * v[j];
        r[k] = clip(((acc + HALF) >>> 30) + coef[4*k+3],
                    -64'sd2147483648, 64'sd2147483647);
      end
    end
    o.x = r[0][31:0]; o.y = r[1][31:0]; o.z = r[2][31:0];
    o.err = degen;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rot_point_t e;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] = 0;
      regs_q[REG_DZ] = 65536;
      stale = 1;
      degen = 0;
      rotated_q.delete();
    end else begin
      if (cfg_we && cfg_index < NUM_REGS) begin
        regs_q[cfg_index] = (cfg_index == REG_ANGLE) ? (cfg_data & 32'h7FFFF) : cfg_data;
        stale = 1;
      end
      if (in_valid && !in_stall) begin
        if (stale) rebuild_matrix();
        rotated_q.push_back(rotate_point(in_x, in_y, in_z));
      end
      if (out_valid && !out_stall) begin
        if (rotated_q.size() == 0) begin
          report("unexpected item, queue size", 1, 0);
        end else begin
          e = rotated_q.pop_front();
          if (out_x !== e.x) report("out_x", out_x, e.x);
          if (out_y !== e.y) report("out_y", out_y, e.y);
          if (out_z !== e.z) report("out_z", out_z, e.z);
          if (out_axis_error !== e.err) report("axis_error", out_axis_error, e.err);
        end
      end
    end
    pending = rotated_q.size();
  end
endmodule

// ===== bench/axis_angle_point_rotator_tb.sv =====
module axis_angle_point_rotator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arp_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_axis_error;
  logic signed [31:0] in_x, in_y, in_z, out_x, out_y, out_z;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int fail_count, pending;
  bit hold_off;
  bit stim_done;

  axis_angle_point_rotator i_dut (.*);

  axis_angle_point_rotator_chk i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
      3: return 32'($urandom_range(0, 8'hFF)) - 32'd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 32'(-205887) & 32'h7FFFF;
      1: return 32'd205887;
      2: return $urandom & 32'h7FFFF;
      default: return 32'(signed'($urandom_range(0, 411774)) - 205887) & 32'h7FFFF;
    endcase
  endfunction

  task automatic write_reg(arp_reg_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    cfg_we <= 0;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_x <= x; in_y <= y; in_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 0;
  endtask

  task automatic set_axis(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                          logic [31:0] ang);
    write_reg(REG_PX, px); write_reg(REG_PY, py); write_reg(REG_PZ, pz);
    write_reg(REG_DX, dx); write_reg(REG_DY, dy); write_reg(REG_DZ, dz);
    write_reg(REG_ANGLE, ang);
  endtask

  initial begin
    hold_off = 0;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 40) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(10, 50)) @(negedge clk);
      end else begin
        case ($urandom_range(0, 19))
          0: out_stall <= 1;
          1, 2, 3: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= 0;
        endcase
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0; in_x = 0; in_y = 0; in_z = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    stim_done = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // defaults, then extremes
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h0001_0000, 32'h0, 32'h8000_0000);
    end_burst(); drain();
    set_axis(32'h7FFF_FFFF, 32'h8000_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
             32'h1_0000, 32'd205887);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    end_burst(); drain();
    // angle beyond pi on both sides, huge direction
    set_axis(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
             32'h3FFFF);
    send_point(32'h1_0000, 32'h2_0000, 32'h3_0000);
    end_burst(); drain();
    write_reg(REG_ANGLE, 32'h40000);
    send_point(32'h1_0000, 32'hFFFF_0000, 32'h5_0000);
    end_burst(); drain();
    write_reg(REG_ANGLE, 32'(-205887) & 32'h7FFFF);
    send_point(32'h1234_5678, 32'h8765_4321, 32'h0);
    end_burst(); drain();
    // degenerate axis (zero, then one still under the limit), then tiny but valid
    set_axis(32'h10_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd1000);
    send_point(32'h1_0000, 32'h1_0000, 32'h1_0000);
    end_burst(); drain();
    write_reg(REG_DX, 32'h1);
    send_point(32'h1_0000, 32'h1_0000, 32'h1_0000);
    end_burst(); drain();
    write_reg(REG_DY, 32'h3);
    send_point(32'h1_0000, 32'h1_0000, 32'h1_0000);
    end_burst(); drain();
    // invalid register index
    cfg_we <= 1; cfg_index <= 3'd7; cfg_data <= $urandom;
    @(negedge clk);
    send_point(32'h2_0000, 32'h0, 32'h0);
    end_burst(); drain();

    for (int ph = 0; ph < 25; ph++) begin
      set_axis(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_angle());
      if (ph == 5) hold_off = 1;
      for (int n = 0; n < 50; n++) send_point(pick_coord(), pick_coord(), pick_coord());
      end_burst(); drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
